/* rtl/hpe_pkg.sv */
// Shared package of the Hoare partition engine.
// Holds command and status codes, the order register index and the controller state type.
// No dependencies.
`default_nettype none

package hpe_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_PART   = 2'd2;
  localparam logic [1:0] CMD_MEDIAN = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_EMPTY  = 2'd1;
  localparam logic [1:0] STS_BEYOND = 2'd2;

  // register word index of the order control register
  localparam logic REG_ORDER = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_OUT,
    ST_MED_RLO,
    ST_MED_RHI,
    ST_MED_C1,
    ST_MED_C2,
    ST_MED_C3,
    ST_MED_WMID,
    ST_MED_WLO,
    ST_MED_WHI,
    ST_SC_INIT,
    ST_SC_LEFT,
    ST_SC_RIGHT,
    ST_SC_SWAP,
    ST_SC_FRD,
    ST_SC_FIN
  } state_t;

endpackage

`default_nettype wire

/* rtl/hoare_partition_engine_unit.sv */
// Top level of the Hoare partition engine: element store, command sequencer
// and APB-style order register. Depends on hpe_pkg.
`default_nettype none

// An item is taken when start is high and busy is low; each item gives exactly
// one result, shown for one cycle with done high, which the receiver must take
// as it comes. A write gives its result in the cycle after it is taken and
// keeps busy low, so writes may follow one another in every cycle. A read
// holds busy while in ST_RD_OUT and gives its result from the store's read data.
// Rejected commands (index or range beyond the store, empty or inverted range)
// answer in the next cycle. A partition with a given pivot holds busy while it
// sets up, inspects elements, exchanges pairs and finishes, and raises done in
// the same cycle as busy falls; a median-of-three partition first reads, orders
// and writes back the first, middle and last elements. The sequencing follows
// from the store: one synchronous memory with one read port and one write port,
// its read port registered. The store has no reset and holds no valid bits:
// reading or partitioning an entry that was never written gives undefined data.
// descending_order (register 0, byte address 0) reverses the signed compare;
// write it only while the block is idle.

module hoare_partition_engine_unit
  import hpe_pkg::*;
#(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          cmd,
  input  wire logic [9:0]          index,
  input  wire logic signed [31:0]  value,
  input  wire logic [10:0]         start_index,
  input  wire logic [10:0]         end_index,
  // result channel
  output logic                     done,
  output logic signed [31:0]       read_value,
  output logic [10:0]              split_index,
  output logic [1:0]               status,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);
  localparam int CW = ((PW > 11) ? PW : 11) + 1;
  localparam int VW = (VALUE_BITS > 32) ? VALUE_BITS : 32;

  typedef logic [VALUE_BITS-1:0] elem_t;
  typedef logic [PW-1:0]         pos_t;

  function automatic logic before_f(input elem_t a, input elem_t b, input logic desc);
    before_f = desc ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
  endfunction

  // ---------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------
  logic desc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ORDER) ? {31'd0, desc} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ORDER) begin
      desc <= pwdata[0];
    end
  end

  // ---------------------------------------------------------------------
  // element store: one write port, one registered read port
  // ---------------------------------------------------------------------
  elem_t          mem [DEPTH];
  elem_t          rdata;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic           we;
  elem_t          wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // ---------------------------------------------------------------------
  // sequencer registers
  // ---------------------------------------------------------------------
  state_t state, state_next;
  pos_t   s, s_next, e, e_next;
  pos_t   lo, lo_next, hi, hi_next, mid, mid_next;
  elem_t  pivot, pivot_next, vs, vs_next;
  elem_t  vlo, vlo_next, vmid, vmid_next, vhi, vhi_next;
  logic   len_two, len_two_next, len_three, len_three_next;
  logic         done_next;
  logic [31:0]  rv_next;
  logic [10:0]  split_next;
  logic [1:0]   status_next;

  // decode of the incoming item
  logic [CW-1:0] idx_w, st_w, en_w, depth_w, len_w, hi_in_w, mid_sum_w;
  logic          idx_bad, range_bad, range_empty;
  logic [VW-1:0] val_wide, rd_wide;
  elem_t         val_elem;

  // widened views of positions
  logic [CW-1:0] s_w, s_p1_w, s_p2_w, e_w, hi_w, mid_w;
  pos_t          s_p1, e_m1;

  assign idx_w       = CW'(index);
  assign st_w        = CW'(start_index);
  assign en_w        = CW'(end_index);
  assign depth_w     = CW'(DEPTH);
  assign len_w       = en_w - st_w;
  assign hi_in_w     = en_w - CW'(1);
  assign mid_sum_w   = st_w + hi_in_w;
  assign idx_bad     = idx_w >= depth_w;
  assign range_bad   = (st_w > depth_w) || (en_w > depth_w);
  assign range_empty = st_w >= en_w;
  assign val_wide    = VW'($unsigned(value));
  assign val_elem    = val_wide[VALUE_BITS-1:0];
  assign rd_wide     = VW'(rdata);

  assign s_p1   = s + PW'(1);
  assign e_m1   = e - PW'(1);
  assign s_w    = CW'(s);
  assign s_p1_w = CW'(s_p1);
  assign s_p2_w = CW'(s) + CW'(2);
  assign e_w    = CW'(e);
  assign hi_w   = CW'(hi);
  assign mid_w  = CW'(mid);

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    s           <= s_next;
    e           <= e_next;
    lo          <= lo_next;
    hi          <= hi_next;
    mid         <= mid_next;
    pivot       <= pivot_next;
    vs          <= vs_next;
    vlo         <= vlo_next;
    vmid        <= vmid_next;
    vhi         <= vhi_next;
    len_two     <= len_two_next;
    len_three   <= len_three_next;
    read_value  <= rv_next;
    split_index <= split_next;
    status      <= status_next;
  end

  always_comb begin
    state_next     = state;
    s_next         = s;
    e_next         = e;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    pivot_next     = pivot;
    vs_next        = vs;
    vlo_next       = vlo;
    vmid_next      = vmid;
    vhi_next       = vhi;
    len_two_next   = len_two;
    len_three_next = len_three;
    done_next      = 1'b0;
    rv_next        = read_value;
    split_next     = split_index;
    status_next    = status;
    raddr          = s[AW-1:0];
    we             = 1'b0;
    waddr          = s[AW-1:0];
    wdata          = vs;

    case (state)
      ST_IDLE: begin
        if (start) begin
          rv_next    = 32'd0;
          split_next = 11'd0;
          case (cmd)
            CMD_WRITE: begin
              done_next = 1'b1;
              if (idx_bad) begin
                status_next = STS_BEYOND;
              end else begin
                status_next = STS_OK;
                we          = 1'b1;
                waddr       = idx_w[AW-1:0];
                wdata       = val_elem;
              end
            end
            CMD_READ: begin
              if (idx_bad) begin
                done_next   = 1'b1;
                status_next = STS_BEYOND;
              end else begin
                raddr      = idx_w[AW-1:0];
                state_next = ST_RD_OUT;
              end
            end
            default: begin
              if (range_bad) begin
                done_next   = 1'b1;
                status_next = STS_BEYOND;
              end else if (range_empty) begin
                done_next   = 1'b1;
                status_next = STS_EMPTY;
              end else if (cmd == CMD_PART) begin
                s_next     = st_w[PW-1:0];
                e_next     = hi_in_w[PW-1:0];
                pivot_next = val_elem;
                state_next = ST_SC_INIT;
              end else if (len_w == CW'(1)) begin
                // single element: it is already its own split
                done_next   = 1'b1;
                status_next = STS_OK;
                split_next  = st_w[10:0];
              end else begin
                lo_next        = st_w[PW-1:0];
                hi_next        = hi_in_w[PW-1:0];
                mid_next       = mid_sum_w[PW:1];
                len_two_next   = (len_w == CW'(2));
                len_three_next = (len_w == CW'(3));
                state_next     = ST_MED_RLO;
              end
            end
          endcase
        end
      end

      ST_RD_OUT: begin
        done_next   = 1'b1;
        status_next = STS_OK;
        rv_next     = rd_wide[31:0];
        state_next  = ST_IDLE;
      end

      // median of three: gather first, last and middle, sort in registers
      ST_MED_RLO: begin
        raddr      = lo[AW-1:0];
        state_next = ST_MED_RHI;
      end

      ST_MED_RHI: begin
        raddr      = hi[AW-1:0];
        vlo_next   = rdata;
        state_next = ST_MED_C1;
      end

      ST_MED_C1: begin
        if (before_f(rdata, vlo, desc)) begin
          vlo_next = rdata;
          vhi_next = vlo;
        end else begin
          vhi_next = rdata;
        end
        if (len_two) begin
          state_next = ST_MED_WLO;
        end else begin
          raddr      = mid[AW-1:0];
          state_next = ST_MED_C2;
        end
      end

      ST_MED_C2: begin
        if (before_f(rdata, vlo, desc)) begin
          vlo_next  = rdata;
          vmid_next = vlo;
        end else begin
          vmid_next = rdata;
        end
        state_next = ST_MED_C3;
      end

      ST_MED_C3: begin
        if (before_f(vhi, vmid, desc)) begin
          vmid_next = vhi;
          vhi_next  = vmid;
        end
        state_next = ST_MED_WMID;
      end

      // write back middle first so the scan never reads it in flight
      ST_MED_WMID: begin
        we         = 1'b1;
        waddr      = mid[AW-1:0];
        wdata      = vmid;
        state_next = ST_MED_WLO;
      end

      ST_MED_WLO: begin
        we         = 1'b1;
        waddr      = lo[AW-1:0];
        wdata      = vlo;
        state_next = ST_MED_WHI;
      end

      ST_MED_WHI: begin
        we    = 1'b1;
        waddr = hi[AW-1:0];
        wdata = vhi;
        if (len_two) begin
          done_next   = 1'b1;
          status_next = STS_OK;
          split_next  = hi_w[10:0];
          state_next  = ST_IDLE;
        end else if (len_three) begin
          done_next   = 1'b1;
          status_next = STS_OK;
          split_next  = mid_w[10:0];
          state_next  = ST_IDLE;
        end else begin
          s_next     = lo + PW'(1);
          e_next     = hi - PW'(1);
          pivot_next = vmid;
          state_next = ST_SC_INIT;
        end
      end

      // Hoare scan over the inclusive range [s, e]
      ST_SC_INIT: begin
        raddr      = s[AW-1:0];
        state_next = (s < e) ? ST_SC_LEFT : ST_SC_FIN;
      end

      ST_SC_LEFT: begin
        if (before_f(rdata, pivot, desc)) begin
          // advance left pointer, prefetch next element
          s_next     = s_p1;
          raddr      = s_p1[AW-1:0];
          state_next = (s_p1 < e) ? ST_SC_LEFT : ST_SC_FIN;
        end else begin
          vs_next    = rdata;
          raddr      = e[AW-1:0];
          state_next = ST_SC_RIGHT;
        end
      end

      ST_SC_RIGHT: begin
        if (before_f(pivot, rdata, desc)) begin
          e_next     = e_m1;
          raddr      = e_m1[AW-1:0];
          state_next = (s_p1 < e) ? ST_SC_RIGHT : ST_SC_FIN;
        end else begin
          // first half of the exchange
          we         = 1'b1;
          waddr      = s[AW-1:0];
          wdata      = rdata;
          state_next = ST_SC_SWAP;
        end
      end

      ST_SC_SWAP: begin
        we     = 1'b1;
        waddr  = e[AW-1:0];
        wdata  = vs;
        s_next = s_p1;
        e_next = e_m1;
        raddr  = s_p1[AW-1:0];
        if (s_p2_w < e_w) begin
          state_next = ST_SC_LEFT;
        end else if (s_p2_w == e_w) begin
          state_next = ST_SC_FIN;
        end else begin
          // next read hits the entry written now: wait in ST_SC_FRD
          state_next = ST_SC_FRD;
        end
      end

      ST_SC_FRD: begin
        raddr      = s[AW-1:0];
        state_next = ST_SC_FIN;
      end

      ST_SC_FIN: begin
        done_next   = 1'b1;
        status_next = STS_OK;
        rv_next     = 32'd0;
        split_next  = before_f(rdata, pivot, desc) ? s_p1_w[10:0] : s_w[10:0];
        state_next  = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
